FILE: rtl/b64se_pkg.sv
package b64se_pkg;

  // Six-bit sextet codes plus the pad code
  localparam int unsigned CodeW   = 7;
  localparam logic [CodeW-1:0] PadCode = 7'd64;

  // Register indexes of the configuration port
  localparam logic CfgLineBreakEnable = 1'b0;
  localparam logic CfgLineLength      = 1'b1;

  // Characters placed in the stream besides the alphabet
  localparam logic [7:0] AsciiCr  = 8'h0d;
  localparam logic [7:0] AsciiLf  = 8'h0a;
  localparam logic [7:0] AsciiPad = 8'h3d;

  // Maximum characters caused by one source byte
  localparam int unsigned MaxChars = 6;
  localparam int unsigned CntW     = $clog2(MaxChars + 1);

  localparam logic [7:0] LineLengthReset = 8'd76;

  // Map a sextet (or the pad code) to its ASCII character
  function automatic logic [7:0] b64_char(input logic [CodeW-1:0] code);
    logic [7:0] ch;
    if (code[6]) begin
      ch = AsciiPad;
    end else if (code[5:0] < 6'd26) begin
      ch = 8'h41 + {2'b00, code[5:0]};
    end else if (code[5:0] < 6'd52) begin
      ch = 8'h61 + {2'b00, code[5:0]} - 8'd26;
    end else if (code[5:0] < 6'd62) begin
      ch = 8'h30 + {2'b00, code[5:0]} - 8'd52;
    end else if (code[5:0] == 6'd62) begin
      ch = 8'h2b;
    end else begin
      ch = 8'h2f;
    end
    return ch;
  endfunction

endpackage

FILE: rtl/base64_stream_encoder_unit.sv
// Streaming base64 encoder (standard alphabet, '=' padding) with optional
// CR LF line breaks. Source bytes enter one per word on the slave side,
// tlast marking the final byte of a message; encoded characters leave one
// per word on the master side, tlast on the final character. A byte that
// opens or extends a group gives nothing; a byte that completes a group,
// or a final byte, gives four characters, or six with a line break. The
// limit is the one-character output port: the six-entry character buffer
// must drain before the next byte is taken, while the output register
// still holds the last character.
module base64_stream_encoder_unit (
  input  logic       clk,
  input  logic       rst,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // source bytes
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  // encoded characters
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // out_last
);
  import b64se_pkg::*;

  // Configuration registers
  logic       line_break_enable;
  logic [7:0] line_length;

  // Encoder state
  logic [7:0] first_pending;
  logic [7:0] second_pending;
  logic [1:0] group_phase;
  logic [7:0] line_chars;

  // Character buffer between the encoder and the output register
  logic [7:0]      buf_char [MaxChars];
  logic [CntW-1:0] buf_cnt;
  logic            buf_last;

  // Next values
  logic [7:0]       first_pending_next;
  logic [7:0]       second_pending_next;
  logic [1:0]       group_phase_next;
  logic [7:0]       line_chars_next;
  logic [7:0]       char_next [MaxChars];
  logic [CntW-1:0]  cnt_next;

  logic             in_take;
  logic             out_load;
  logic             brk;
  logic             emit;
  logic [7:0]       b0;
  logic [7:0]       b1;
  logic [CodeW-1:0] code [4];

  assign s_tready = (buf_cnt == '0);
  assign in_take  = s_tvalid && s_tready;
  assign out_load = (buf_cnt != '0) && (!m_tvalid || m_tready);

  // Encode one source byte
  always_comb begin
    first_pending_next  = first_pending;
    second_pending_next = second_pending;
    line_chars_next     = line_chars;
    group_phase_next    = group_phase;

    b0 = (group_phase == 2'd0) ? s_tdata : first_pending;
    b1 = (group_phase == 2'd1) ? s_tdata : second_pending;

    emit = s_tlast || (group_phase == 2'd2);
    brk  = emit && line_break_enable && (line_chars == line_length);

    code[0] = {1'b0, b0[7:2]};
    if (group_phase == 2'd0) begin
      code[1] = {1'b0, b0[1:0], 4'b0000};
      code[2] = PadCode;
      code[3] = PadCode;
      first_pending_next = s_tdata;
      group_phase_next   = 2'd1;
    end else if (group_phase == 2'd1) begin
      code[1] = {1'b0, b0[1:0], b1[7:4]};
      code[2] = {1'b0, b1[3:0], 2'b00};
      code[3] = PadCode;
      second_pending_next = s_tdata;
      group_phase_next    = 2'd2;
    end else begin
      code[1] = {1'b0, b0[1:0], b1[7:4]};
      code[2] = {1'b0, b1[3:0], s_tdata[7:6]};
      code[3] = {1'b0, s_tdata[5:0]};
      group_phase_next = 2'd0;
    end

    // line counter: break clears it, a full group advances it while breaks are enabled, a final byte clears it
    if (brk) begin
      line_chars_next = 8'd0;
    end
    if ((group_phase == 2'd2) && line_break_enable) begin
      line_chars_next = line_chars_next + 8'd4;
    end
    if (s_tlast) begin
      group_phase_next = 2'd0;
      line_chars_next  = 8'd0;
    end

    // character list, CR LF first when breaking
    if (brk) begin
      char_next[0] = AsciiCr;
      char_next[1] = AsciiLf;
      for (int i = 0; i < 4; i++) begin
        char_next[i+2] = b64_char(code[i]);
      end
      cnt_next = CntW'(6);
    end else begin
      for (int i = 0; i < 4; i++) begin
        char_next[i] = b64_char(code[i]);
      end
      char_next[4] = AsciiCr;
      char_next[5] = AsciiLf;
      cnt_next = emit ? CntW'(4) : CntW'(0);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_break_enable <= 1'b0;
      line_length       <= LineLengthReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgLineBreakEnable: line_break_enable <= cfg_data[0];
        CfgLineLength:      line_length       <= cfg_data;
        default:            line_length       <= line_length;
      endcase
    end
  end

  // Encoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending  <= 8'd0;
      second_pending <= 8'd0;
      group_phase    <= 2'd0;
      line_chars     <= 8'd0;
    end else if (in_take) begin
      first_pending  <= first_pending_next;
      second_pending <= second_pending_next;
      group_phase    <= group_phase_next;
      line_chars     <= line_chars_next;
    end
  end

  // Character buffer: filled on a taken byte, shifted into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= '0;
    end else if (in_take) begin
      buf_cnt <= cnt_next;
    end else if (out_load) begin
      buf_cnt <= buf_cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      buf_last <= s_tlast;
      for (int i = 0; i < MaxChars; i++) begin
        buf_char[i] <= char_next[i];
      end
    end else if (out_load) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        buf_char[i] <= buf_char[i+1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= buf_char[0];
      m_tlast <= buf_last && (buf_cnt == CntW'(1));
    end
  end

endmodule

FILE: bench/tb_base64_stream_encoder_unit.sv
`timescale 1ns / 1ps

module tb_base64_stream_encoder_unit;
  import b64se_pkg::*;

  // Standard alphabet, code 0 in the top byte
  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  // Cycles allowed after the last character for a byte still in flight
  localparam int unsigned SettleCycles = 8;

  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data  = 8'h00;
  logic       s_tvalid  = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata   = 8'h00;
  logic       s_tlast   = 1'b0;
  logic       m_tvalid;
  logic       m_tready  = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  // No random idling on either side while set
  bit quiet = 1'b0;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } char_rec_t;

  base64_stream_encoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Encoder model plus the queue of characters still owed by the block
  class b64_scoreboard;
    bit         brk_en;
    logic [7:0] line_len;
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic [1:0] phase;
    logic [7:0] line_cnt;
    char_rec_t  expected_chars[$];
    int         mismatches;

    function new();
      brk_en     = 1'b0;
      line_len   = LineLengthReset;
      first_b    = 8'h00;
      second_b   = 8'h00;
      phase      = 2'd0;
      line_cnt   = 8'h00;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == CfgLineBreakEnable) begin
        brk_en = val[0];
      end else begin
        line_len = val;
      end
    endfunction

    function void push_char(logic [7:0] ch);
      expected_chars.push_back('{out_char: ch, out_last: 1'b0});
    endfunction

    function void push_code(logic [6:0] code);
      if (code == PadCode) begin
        push_char(AsciiPad);
      end else begin
        push_char(Alphabet[8*(63 - int'(code[5:0])) +: 8]);
      end
    endfunction

    // CR LF when the line is full; plain 8-bit compare, so zero hits only at a zero count
    function void line_break();
      if (brk_en && line_cnt == line_len) begin
        push_char(AsciiCr);
        push_char(AsciiLf);
        line_cnt = 8'h00;
      end
    endfunction

    // Predict the characters caused by one accepted source byte
    function void encode_byte(logic [7:0] b, logic fin);
      int        base;
      char_rec_t tail;
      base = expected_chars.size();
      case (phase)
        2'd0: begin
          first_b = b;
          phase   = 2'd1;
          if (fin) begin
            line_break();
            push_code({1'b0, first_b[7:2]});
            push_code({1'b0, first_b[1:0], 4'b0000});
            push_code(PadCode);
            push_code(PadCode);
          end
        end
        2'd1: begin
          second_b = b;
          phase    = 2'd2;
          if (fin) begin
            line_break();
            push_code({1'b0, first_b[7:2]});
            push_code({1'b0, first_b[1:0], second_b[7:4]});
            push_code({1'b0, second_b[3:0], 2'b00});
            push_code(PadCode);
          end
        end
        default: begin
          line_break();
          if (brk_en) line_cnt = line_cnt + 8'd4;
          push_code({1'b0, first_b[7:2]});
          push_code({1'b0, first_b[1:0], second_b[7:4]});
          push_code({1'b0, second_b[3:0], b[7:6]});
          push_code({1'b0, b[5:0]});
          phase = 2'd0;
        end
      endcase
      // end of message: flag the last character, restart group and line
      if (fin) begin
        if (expected_chars.size() > base) begin
          tail = expected_chars.pop_back();
          tail.out_last = 1'b1;
          expected_chars.push_back(tail);
        end
        phase    = 2'd0;
        line_cnt = 8'h00;
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      char_rec_t exp_rec;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: out_char %02h out_last %0b", ch, last);
        mismatches++;
      end else begin
        exp_rec = expected_chars.pop_front();
        if (ch !== exp_rec.out_char) begin
          $error("out_char: expected %02h, got %02h", exp_rec.out_char, ch);
          mismatches++;
        end
        if (last !== exp_rec.out_last) begin
          $error("out_last: expected %0b, got %0b", exp_rec.out_last, last);
          mismatches++;
        end
      end
    endfunction
  endclass

  b64_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // Register write, only while the block is idle
  task automatic cfg_write(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // One source word; tvalid stays high on return unless the caller drops it
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    sb.encode_byte(b, fin);
  endtask

  task automatic send_message(input int n, input bit with_final);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom_range(0, 255)), with_final && (i == n - 1));
    end
  endtask

  // Hold the sender until every owed character has been taken
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic settle_idle();
    drain();
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_line_length();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd4;
      2: return 8'd252;
      3: return 8'd255;
      4: return LineLengthReset;
      5: return 8'($urandom_range(1, 8) * 4);
      6: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(1, 63) * 4);
    endcase
  endfunction

  // Receiver: random stall before each character, then check it
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_char(m_tdata, m_tlast);
    end
  end

  // Main sequence
  initial begin
    int items;
    int sent;
    int phase_items;
    int n;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: single-byte and two-byte tails, full group with + and /
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(8'hfb, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hbf, 1'b1);
    settle_idle();

    // shortest line: break between groups and ahead of the tail group
    cfg_write(CfgLineBreakEnable, 8'h01);
    cfg_write(CfgLineLength, 8'd4);
    send_byte(8'h4d, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6e, 1'b0);
    send_byte(8'h4d, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6e, 1'b0);
    send_byte(8'h4d, 1'b1);
    settle_idle();

    // zero length: CR LF ahead of the first group, none ahead of the tail group
    cfg_write(CfgLineLength, 8'd0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    settle_idle();

    // enable dropped mid-message: line count held, break on re-enable
    cfg_write(CfgLineLength, 8'd4);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    settle_idle();
    cfg_write(CfgLineBreakEnable, 8'h00);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    settle_idle();
    cfg_write(CfgLineBreakEnable, 8'h01);
    send_byte(8'h0a, 1'b1);
    settle_idle();
    items = 24;

    // random phases: new settings, then mostly whole messages
    while (items < 340) begin
      cfg_write(CfgLineBreakEnable, ($urandom_range(0, 3) != 0) ? 8'h01 : 8'h00);
      cfg_write(CfgLineLength, pick_line_length());
      quiet       = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(15, 45);
      sent        = 0;
      while (sent < phase_items) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 260) : $urandom_range(1, 12);
        if ($urandom_range(0, 15) == 0) drain();
        // an open message runs on into the next one
        send_message(n, $urandom_range(0, 9) != 0);
        sent += n;
      end
      settle_idle();
      items += sent;
    end

    repeat (16) @(posedge clk);
    if (sb.expected_chars.size() != 0) begin
      $error("%0d characters never arrived", sb.expected_chars.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
